// File: rtl/shaep_pkg.sv
// Shared types, constants and helper functions for the SHA-1 entropy pool generator.
// Has no dependencies; every other file in rtl imports it.
package shaep_pkg;

  localparam int DIGEST_BYTES = 20;
  localparam int QUEUE_DEPTH  = 2;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);

  localparam logic        OP_ADD = 1'b0;
  localparam logic        OP_GET = 1'b1;
  localparam logic [15:0] THRESH_RESET = 16'd80;

  localparam logic [159:0] SHA_INIT =
    160'h67452301_EFCDAB89_98BADCFE_10325476_C3D2E1F0;

  typedef struct packed {
    logic        operation;
    logic [7:0]  data_byte;
    logic [11:0] entropy_credit;
    logic        end_of_call;
  } req_t;

  typedef struct packed {
    logic [7:0] random_byte;
    logic       ready_res;
  } rsp_t;

  typedef enum logic [1:0] {
    KIND_ADD      = 2'd0,
    KIND_ADD_LAST = 2'd1,
    KIND_GET      = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  data;
    logic [11:0] credit;
  } item_t;

  typedef struct packed {
    logic busy;
    logic done;
  } sha_status_t;

  // One padded block for a 20-byte message: 0x80 marker and a 160-bit length.
  function automatic logic [511:0] mix_block(input logic [159:0] msg);
    mix_block = {msg, 8'h80, 328'd0, 16'h00A0};
  endfunction

  function automatic logic [31:0] sha_k(input logic [6:0] rnd);
    if (rnd < 7'd20)      sha_k = 32'h5A827999;
    else if (rnd < 7'd40) sha_k = 32'h6ED9EBA1;
    else if (rnd < 7'd60) sha_k = 32'h8F1BBCDC;
    else                  sha_k = 32'hCA62C1D6;
  endfunction

endpackage

// File: rtl/shaep_front.sv
// Front end: accepts request words, classifies them and buffers them in a short queue.
// Depends on shaep_pkg.
module shaep_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  shaep_pkg::req_t      in_data_i,
  output logic                 item_valid_o,
  output shaep_pkg::item_t     item_o,
  input  logic                 item_pop_i
);
  import shaep_pkg::*;

  item_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [QPTR_W:0]    cnt_q;
  logic               full, empty, push, pop;
  item_t              item_new;

  assign full  = (cnt_q == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty = (cnt_q == '0);
  assign push  = in_valid_i && !full;
  assign pop   = item_pop_i && !empty;

  always_comb begin
    item_new.data   = in_data_i.data_byte;
    item_new.credit = in_data_i.entropy_credit;
    if (in_data_i.operation == OP_GET) begin
      item_new.kind = KIND_GET;
    end else if (in_data_i.end_of_call) begin
      item_new.kind = KIND_ADD_LAST;
    end else begin
      item_new.kind = KIND_ADD;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= item_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      case ({push, pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  assign in_stall_o   = full;
  assign item_valid_o = !empty;
  assign item_o       = mem_q[rd_ptr_q];

endmodule

// File: rtl/shaep_sha1.sv
// Iterative SHA-1 compression unit: one round per cycle, 80 rounds per block.
// Depends on shaep_pkg.
module shaep_sha1 (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [159:0]             chain_i,
  input  logic [511:0]             block_i,
  output shaep_pkg::sha_status_t   status_o,
  output logic [159:0]             digest_o
);
  import shaep_pkg::*;

  logic [31:0]  a_q, b_q, c_q, d_q, e_q;
  logic [31:0]  w_q [16];
  logic [159:0] h_q;
  logic [6:0]   rnd_q;
  logic         busy_q, done_q;
  logic [31:0]  f, t, w_new, wx;

  always_comb begin
    if (rnd_q < 7'd20) begin
      f = (b_q & c_q) | (~b_q & d_q);
    end else if (rnd_q < 7'd40) begin
      f = b_q ^ c_q ^ d_q;
    end else if (rnd_q < 7'd60) begin
      f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
    end else begin
      f = b_q ^ c_q ^ d_q;
    end
    t     = {a_q[26:0], a_q[31:27]} + f + e_q + sha_k(rnd_q) + w_q[0];
    wx    = w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0];
    w_new = {wx[30:0], wx[31]};
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      h_q <= chain_i;
      a_q <= chain_i[159:128];
      b_q <= chain_i[127:96];
      c_q <= chain_i[95:64];
      d_q <= chain_i[63:32];
      e_q <= chain_i[31:0];
      for (int i = 0; i < 16; i++) begin
        w_q[i] <= block_i[511 - 32*i -: 32];
      end
    end else if (busy_q) begin
      a_q <= t;
      b_q <= a_q;
      c_q <= {b_q[1:0], b_q[31:2]};
      d_q <= c_q;
      e_q <= d_q;
      for (int i = 0; i < 15; i++) begin
        w_q[i] <= w_q[i+1];
      end
      w_q[15] <= w_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      rnd_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        rnd_q  <= '0;
      end else if (busy_q) begin
        rnd_q <= rnd_q + 1'b1;
        if (rnd_q == 7'd79) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign status_o.busy = busy_q;
  assign status_o.done = done_q;
  assign digest_o = {h_q[159:128] + a_q, h_q[127:96] + b_q, h_q[95:64] + c_q,
                     h_q[63:32] + d_q, h_q[31:0] + e_q};

endmodule

// File: rtl/shaep_core.sv
// Back end: pool absorb, padding, reseed, mixing and byte output sequencer.
// Depends on shaep_pkg and shaep_sha1.
module shaep_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [15:0]         thresh_i,
  input  logic                item_valid_i,
  input  shaep_pkg::item_t    item_i,
  output logic                item_pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output shaep_pkg::rsp_t     out_data_o
);
  import shaep_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_PAD    = 8'b0000_0010,
    S_PGO    = 8'b0000_0100,
    S_PWAIT  = 8'b0000_1000,
    S_M1GO   = 8'b0001_0000,
    S_M1WAIT = 8'b0010_0000,
    S_M2GO   = 8'b0100_0000,
    S_M2WAIT = 8'b1000_0000
  } state_e;

  state_e            state_q, state_d;
  logic [159:0]      chain_q, chain_d, main_q, main_d;
  logic [511:0]      blk_q, blk_d;
  logic [5:0]        pos_q, pos_d;
  logic [63:0]       len_q, len_d, lensh_q, lensh_d;
  logic [15:0]       cnt_q, cnt_d, sat;
  logic [16:0]       sum;
  logic [7:0]        ob_q [DIGEST_BYTES];
  logic [7:0]        ob_d [DIGEST_BYTES];
  logic [4:0]        idx_q, idx_d;
  logic              seeded_q, seeded_d, reseed_q, reseed_d;
  logic              pad_act_q, pad_act_d, pad_first_q, pad_first_d;
  logic              wrap_q, wrap_d, fin_q, fin_d;
  logic              ovalid_q, ovalid_d;
  rsp_t              odata_q, odata_d;
  logic              out_free, pop;
  logic [7:0]        pad_byte;

  logic              sha_start;
  logic [159:0]      sha_chain, sha_digest;
  logic [511:0]      sha_block;
  sha_status_t       sha_st;

  assign sha_start = (state_q == S_PGO) || (state_q == S_M1GO) || (state_q == S_M2GO);
  assign sha_chain = (state_q == S_PGO) ? chain_q : SHA_INIT;
  assign sha_block = (state_q == S_PGO) ? blk_q
                   : mix_block((state_q == S_M2GO) ? ~main_q : main_q);

  shaep_sha1 u_sha1 (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (sha_start),
    .chain_i  (sha_chain),
    .block_i  (sha_block),
    .status_o (sha_st),
    .digest_o (sha_digest)
  );

  assign out_free = !ovalid_q || !out_stall_i;
  assign pop = (state_q == S_IDLE) && item_valid_i
            && ((item_i.kind != KIND_GET) || out_free);
  assign sum = {1'b0, cnt_q} + {5'd0, item_i.credit};
  assign sat = sum[16] ? 16'hFFFF : sum[15:0];

  always_comb begin
    if (pad_first_q) begin
      pad_byte = 8'h80;
    end else if (!wrap_q && (pos_q >= 6'd56)) begin
      pad_byte = lensh_q[63:56];
    end else begin
      pad_byte = 8'h00;
    end
  end

  always_comb begin
    state_d     = state_q;
    chain_d     = chain_q;
    main_d      = main_q;
    blk_d       = blk_q;
    pos_d       = pos_q;
    len_d       = len_q;
    lensh_d     = lensh_q;
    cnt_d       = cnt_q;
    ob_d        = ob_q;
    idx_d       = idx_q;
    seeded_d    = seeded_q;
    reseed_d    = reseed_q;
    pad_act_d   = pad_act_q;
    pad_first_d = pad_first_q;
    wrap_d      = wrap_q;
    fin_d       = fin_q;
    ovalid_d    = ovalid_q && out_stall_i;
    odata_d     = odata_q;

    unique case (state_q)
      S_IDLE: begin
        if (pop) begin
          case (item_i.kind) inside
            KIND_ADD, KIND_ADD_LAST: begin
              blk_d    = {blk_q[503:0], item_i.data};
              pos_d    = pos_q + 1'b1;
              len_d    = len_q + 1'b1;
              reseed_d = 1'b0;
              if (item_i.kind == KIND_ADD_LAST) begin
                cnt_d    = sat;
                reseed_d = (sat >= thresh_i);
              end
              if (pos_q == 6'd63) begin
                state_d = S_PGO;
              end else if (reseed_d) begin
                pad_act_d   = 1'b1;
                pad_first_d = 1'b1;
                wrap_d      = (pos_d >= 6'd56);
                lensh_d     = {len_d[60:0], 3'b000};
                state_d     = S_PAD;
              end
            end
            KIND_GET: begin
              ovalid_d = 1'b1;
              if (seeded_q) begin
                odata_d.random_byte = ob_q[idx_q];
                odata_d.ready_res   = 1'b1;
                idx_d = idx_q + 1'b1;
                if (idx_q == 5'(DIGEST_BYTES - 1)) begin
                  state_d = S_M1GO;
                end
              end else begin
                odata_d.random_byte = 8'h00;
                odata_d.ready_res   = 1'b0;
              end
            end
            default: ;
          endcase
        end
      end
      S_PAD: begin
        pad_first_d = 1'b0;
        if (!pad_first_q && !wrap_q && (pos_q >= 6'd56)) begin
          lensh_d = {lensh_q[55:0], 8'h00};
        end
        blk_d = {blk_q[503:0], pad_byte};
        pos_d = pos_q + 1'b1;
        if (pos_q == 6'd63) begin
          fin_d   = !wrap_q;
          wrap_d  = 1'b0;
          state_d = S_PGO;
        end
      end
      S_PGO: state_d = S_PWAIT;
      S_PWAIT: begin
        if (sha_st.done) begin
          chain_d = sha_digest;
          if (fin_q) begin
            // Fold the pool digest into the state and restart the pool.
            main_d    = main_q ^ sha_digest;
            chain_d   = SHA_INIT;
            pos_d     = '0;
            len_d     = '0;
            cnt_d     = '0;
            seeded_d  = 1'b1;
            pad_act_d = 1'b0;
            fin_d     = 1'b0;
            reseed_d  = 1'b0;
            state_d   = S_M1GO;
          end else if (pad_act_q) begin
            state_d = S_PAD;
          end else if (reseed_q) begin
            pad_act_d   = 1'b1;
            pad_first_d = 1'b1;
            wrap_d      = (pos_q >= 6'd56);
            lensh_d     = {len_q[60:0], 3'b000};
            state_d     = S_PAD;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_M1GO: state_d = S_M1WAIT;
      S_M1WAIT: begin
        if (sha_st.done) begin
          for (int i = 0; i < DIGEST_BYTES; i++) begin
            ob_d[i] = sha_digest[159 - 8*i -: 8];
          end
          idx_d   = '0;
          state_d = S_M2GO;
        end
      end
      S_M2GO: state_d = S_M2WAIT;
      S_M2WAIT: begin
        if (sha_st.done) begin
          main_d  = sha_digest;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    blk_q   <= blk_d;
    lensh_q <= lensh_d;
    odata_q <= odata_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      chain_q     <= SHA_INIT;
      main_q      <= '0;
      pos_q       <= '0;
      len_q       <= '0;
      cnt_q       <= '0;
      for (int i = 0; i < DIGEST_BYTES; i++) begin
        ob_q[i] <= '0;
      end
      idx_q       <= '0;
      seeded_q    <= 1'b0;
      reseed_q    <= 1'b0;
      pad_act_q   <= 1'b0;
      pad_first_q <= 1'b0;
      wrap_q      <= 1'b0;
      fin_q       <= 1'b0;
      ovalid_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      chain_q     <= chain_d;
      main_q      <= main_d;
      pos_q       <= pos_d;
      len_q       <= len_d;
      cnt_q       <= cnt_d;
      ob_q        <= ob_d;
      idx_q       <= idx_d;
      seeded_q    <= seeded_d;
      reseed_q    <= reseed_d;
      pad_act_q   <= pad_act_d;
      pad_first_q <= pad_first_d;
      wrap_q      <= wrap_d;
      fin_q       <= fin_d;
      ovalid_q    <= ovalid_d;
    end
  end

  assign item_pop_o  = pop;
  assign out_valid_o = ovalid_q;
  assign out_data_o  = odata_q;

  // The index reaches the digest size only while the following mix is running.
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sha_start |-> !sha_st.busy) else $error("compression started while busy");
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> (idx_q < 5'(DIGEST_BYTES)))
    else $error("output index out of range");
  a_mix_seeded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_M1GO) |-> seeded_q) else $error("mix before seeding");
  a_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sha_st.done |-> ((state_q == S_PWAIT) || (state_q == S_M1WAIT) ||
                     (state_q == S_M2WAIT))) else $error("unexpected digest");

endmodule

// File: rtl/sha1_entropy_pool_rng.sv
// Top level: threshold register, front queue and back-end sequencer.
// A get word is answered from the output register once the idle sequencer takes it
// and the output is free; an add word is absorbed into the pool, and each full 64-byte
// block is compressed by the 80-round iterative SHA-1 unit. The 20th seeded get byte
// after a mix starts a two-compression mix; reseeds pad up to 72 bytes, compress, mix.
// Reset (asynchronous, active low) clears the pool, counts and state; threshold returns to 80.
module sha1_entropy_pool_rng (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  shaep_pkg::req_t   in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output shaep_pkg::rsp_t   out_data_o,
  input  logic              cfg_we_i,
  input  logic [15:0]       cfg_data_i
);
  import shaep_pkg::*;

  logic [15:0] thresh_q;
  logic        item_valid, item_pop;
  item_t       item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= THRESH_RESET;
    end else if (cfg_we_i) begin
      thresh_q <= cfg_data_i;
    end
  end

  shaep_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_data_i    (in_data_i),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_pop_i   (item_pop)
  );

  shaep_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .thresh_i     (thresh_q),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_pop_o   (item_pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o)
  );

endmodule
